// ===== hw/rtl/bris_pkg.sv =====
package bris_pkg;

	localparam int MAX_BITSETS_DEF      = 4;
	localparam int WORDS_PER_BITSET_DEF = 64;

	localparam int WORD_BITS = 64;
	localparam int POS_W     = 14;  // element positions up to 8192
	localparam int BLK_W     = 8;   // word positions up to 128
	localparam int CURSOR_W  = 13;
	localparam int START_W   = 12;
	localparam int LEN_W     = 13;
	localparam int TOTAL_W   = 13;
	localparam int NSET_W    = 3;
	localparam int SEL_W     = 2;
	localparam int WIDX_W    = 6;
	localparam int KIND_W    = 2;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [WORD_BITS-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REWIND = 2'd2;

	localparam logic REG_BITSETS_IN_USE = 1'b0;
	localparam logic REG_ELEMENT_TOTAL  = 1'b1;

	typedef struct packed {
		logic [NSET_W-1:0]  bitsets_in_use;
		logic [TOTAL_W-1:0] element_total;
	} cfg_t;

	// index of the lowest set bit; isolate it, then encode the one-hot word
	function automatic logic [5:0] lowest_set(input logic [WORD_BITS-1:0] x);
		logic [WORD_BITS-1:0] iso;
		logic [5:0]           idx;
		iso = x & (~x + 64'd1);
		for (int b = 0; b < 6; b++) begin
			idx[b] = 1'b0;
			for (int k = 0; k < WORD_BITS; k++) begin
				if (k[b]) begin
					idx[b] = idx[b] | iso[k];
				end
			end
		end
		return idx;
	endfunction

endpackage

// ===== hw/rtl/bris_if.sv =====
interface bris_in_if;
	logic                         valid;
	logic                         ready;
	logic [bris_pkg::KIND_W-1:0]  kind;
	logic [bris_pkg::SEL_W-1:0]   bitset_select;
	logic [bris_pkg::WIDX_W-1:0]  word_index;
	logic [bris_pkg::WORD_BITS-1:0] word_value;

	modport source (output valid, kind, bitset_select, word_index, word_value, input ready);
	modport sink (input valid, kind, bitset_select, word_index, word_value, output ready);
endinterface

interface bris_out_if;
	logic                          valid;
	logic                          ready;
	logic                          run_found;
	logic [bris_pkg::START_W-1:0]  run_start;
	logic [bris_pkg::LEN_W-1:0]    run_length;

	modport source (output valid, run_found, run_start, run_length, input ready);
	modport sink (input valid, run_found, run_start, run_length, output ready);
endinterface

// ===== hw/rtl/bris_ram.sv =====
module bris_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bris_cfg.sv =====
module bris_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bris_pkg::APB_AW-1:0] paddr,
	input  logic [bris_pkg::APB_DW-1:0] pwdata,
	output logic [bris_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output bris_pkg::cfg_t              cfg
);

	bris_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bitsets_in_use <= bris_pkg::NSET_W'(1);
			cfg_q.element_total  <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				bris_pkg::REG_BITSETS_IN_USE: begin
					cfg_q.bitsets_in_use <= pwdata[bris_pkg::NSET_W-1:0];
				end
				bris_pkg::REG_ELEMENT_TOTAL: begin
					cfg_q.element_total <= pwdata[bris_pkg::TOTAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bris_pkg::REG_BITSETS_IN_USE: prdata = bris_pkg::APB_DW'(cfg_q.bitsets_in_use);
			bris_pkg::REG_ELEMENT_TOTAL:  prdata = bris_pkg::APB_DW'(cfg_q.element_total);
			default:                      prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/bris_scan.sv =====
module bris_scan #(
	parameter int MAX_BITSETS      = bris_pkg::MAX_BITSETS_DEF,
	parameter int WORDS_PER_BITSET = bris_pkg::WORDS_PER_BITSET_DEF,
	localparam int DEPTH  = MAX_BITSETS * WORDS_PER_BITSET,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bris_pkg::cfg_t                 cfg,
	bris_in_if.sink                        in_ch,
	bris_out_if.source                     out_ch,
	output logic                           mem_we,
	output logic [ADDR_W-1:0]              mem_waddr,
	output logic [bris_pkg::WORD_BITS-1:0] mem_wdata,
	output logic                           mem_re,
	output logic [ADDR_W-1:0]              mem_raddr,
	input  logic [bris_pkg::WORD_BITS-1:0] mem_rdata
);

	localparam int SET_W = (MAX_BITSETS > 1) ? $clog2(MAX_BITSETS) : 1;
	localparam int CNT_W = $clog2(MAX_BITSETS + 1);
	localparam int POS_W = bris_pkg::POS_W;
	localparam int BLK_W = bris_pkg::BLK_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SEEK   = 6'b000010,
		S_SCAN   = 6'b000100,
		S_RUNEND = 6'b001000,
		S_EVAL   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t                        state_q;
	logic                          clearing_q;
	logic [ADDR_W-1:0]             clr_q;
	logic [bris_pkg::CURSOR_W-1:0] cursor_q;
	logic [SET_W-1:0]              i_q;
	logic                          out_valid_q;

	logic [POS_W-1:0]              pos_q;
	logic [BLK_W-1:0]              blk_q;
	logic [5:0]                    s_q;
	logic                          first_q;
	logic [POS_W-1:0]              rs_q;
	logic [POS_W-1:0]              re_q;
	logic [POS_W-1:0]              last_q;
	logic                          res_found_q;
	logic [bris_pkg::START_W-1:0]  res_start_q;
	logic [bris_pkg::LEN_W-1:0]    res_len_q;
	logic                          out_found_q;
	logic [bris_pkg::START_W-1:0]  out_start_q;
	logic [bris_pkg::LEN_W-1:0]    out_len_q;

	logic                          accept;
	logic                          wr_item;
	logic [CNT_W-1:0]              n_eff;
	logic [BLK_W-1:0]              nblk_raw;
	logic [BLK_W-1:0]              nblk;
	logic [bris_pkg::TOTAL_W-1:0]  total_m1;
	logic [POS_W-1:0]              total_ext;
	logic [BLK_W-1:0]              pos_blk;
	logic [BLK_W-1:0]              blk_next;
	logic [bris_pkg::WORD_BITS-1:0] word_mask;
	logic [bris_pkg::WORD_BITS-1:0] start_hits;
	logic [bris_pkg::WORD_BITS-1:0] end_hits;
	logic [5:0]                    hit_pos;
	logic                          trim;
	logic [POS_W-1:0]              last_new;
	logic [POS_W-1:0]              len_a;
	logic [POS_W-1:0]              len_b;
	logic [POS_W-1:0]              len_min;
	logic                          eval_fail;
	logic                          restart;
	logic                          last_set;
	logic                          out_free;

	function automatic logic [ADDR_W-1:0] word_addr(input logic [SET_W-1:0] set,
			input logic [BLK_W-1:0] blk);
		return ADDR_W'(32'(set) * WORDS_PER_BITSET + 32'(blk));
	endfunction

	assign in_ch.ready      = (state_q == S_IDLE) && !clearing_q;
	assign accept           = in_ch.valid && in_ch.ready;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.run_found  = out_found_q;
	assign out_ch.run_start  = out_start_q;
	assign out_ch.run_length = out_len_q;
	assign out_free         = !out_valid_q || out_ch.ready;

	always_comb begin
		if (cfg.bitsets_in_use == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(cfg.bitsets_in_use) > MAX_BITSETS) begin
			n_eff = CNT_W'(MAX_BITSETS);
		end else begin
			n_eff = CNT_W'(cfg.bitsets_in_use);
		end
		total_m1  = cfg.element_total - 13'd1;
		nblk_raw  = BLK_W'({1'b0, total_m1[12:6]}) + 8'd1;
		nblk      = (32'(nblk_raw) > WORDS_PER_BITSET) ? BLK_W'(WORDS_PER_BITSET) : nblk_raw;
		total_ext = POS_W'(cfg.element_total);
	end

	assign pos_blk    = pos_q[POS_W-1:6];
	assign blk_next   = blk_q + 8'd1;
	assign word_mask  = first_q ? (bris_pkg::ALL_ONES << s_q) : bris_pkg::ALL_ONES;
	assign start_hits = mem_rdata & word_mask;
	assign end_hits   = ~mem_rdata & word_mask;
	// one priority encoder serves both the start and the end search
	assign hit_pos    = bris_pkg::lowest_set((state_q == S_SCAN) ? start_hits : end_hits);

	always_comb begin
		trim      = (i_q != '0) && (re_q > last_q);
		last_new  = trim ? last_q : re_q;
		len_a     = last_new - rs_q;
		len_b     = total_ext - rs_q;
		len_min   = (len_a > len_b) ? len_b : len_a;
		eval_fail = (rs_q >= total_ext) || (rs_q == re_q);
		restart   = (i_q != '0) && (rs_q >= last_q);
		last_set  = (CNT_W'(i_q) + CNT_W'(1)) == n_eff;
	end

	// memory ports: clearing pass owns the write side after reset
	always_comb begin
		wr_item = accept && (in_ch.kind == bris_pkg::KIND_WRITE)
			&& (32'(in_ch.bitset_select) < MAX_BITSETS)
			&& (32'(in_ch.word_index) < WORDS_PER_BITSET);
		mem_we    = clearing_q || wr_item;
		mem_waddr = clearing_q ? clr_q
			: ADDR_W'(32'(in_ch.bitset_select) * WORDS_PER_BITSET + 32'(in_ch.word_index));
		mem_wdata = clearing_q ? '0 : in_ch.word_value;
		case (state_q)
			S_SEEK:   mem_re = pos_blk < nblk;
			S_SCAN:   mem_re = (start_hits == '0) && (blk_next < nblk);
			S_RUNEND: mem_re = (end_hits == '0) && (blk_next != nblk);
			default:  mem_re = 1'b0;
		endcase
		mem_raddr = word_addr(i_q, (state_q == S_SEEK) ? pos_blk : blk_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			cursor_q    <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + ADDR_W'(1);
				if (32'(clr_q) == DEPTH - 1) begin
					clearing_q <= 1'b0;
				end
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_ch.kind)
							bris_pkg::KIND_REWIND: begin
								cursor_q <= '0;
							end
							bris_pkg::KIND_FIND: begin
								i_q <= '0;
								if (cfg.element_total == '0) begin
									cursor_q <= '0;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_SEEK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SEEK: begin
					if (pos_blk >= nblk) begin
						cursor_q <= '0;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (start_hits == '0) begin
						if (blk_next >= nblk) begin
							cursor_q <= '0;
							state_q  <= S_DONE;
						end
					end else begin
						state_q <= S_RUNEND;
					end
				end
				S_RUNEND: begin
					if (end_hits != '0 || blk_next == nblk) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (eval_fail) begin
						cursor_q <= '0;
						state_q  <= S_DONE;
					end else if (restart) begin
						i_q     <= '0;
						state_q <= S_SEEK;
					end else if (last_set) begin
						cursor_q <= last_new[bris_pkg::CURSOR_W-1:0];
						state_q  <= S_DONE;
					end else begin
						i_q     <= i_q + SET_W'(1);
						state_q <= S_SEEK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && in_ch.kind == bris_pkg::KIND_FIND) begin
					pos_q       <= POS_W'(cursor_q);
					res_found_q <= 1'b0;
					res_start_q <= '0;
					res_len_q   <= '0;
				end
			end
			S_SEEK: begin
				blk_q   <= pos_blk;
				s_q     <= pos_q[5:0];
				first_q <= 1'b1;
			end
			S_SCAN: begin
				if (start_hits == '0) begin
					blk_q   <= blk_next;
					first_q <= 1'b0;
				end else begin
					// word stays in the read register for the run-end search
					rs_q    <= {blk_q, hit_pos};
					s_q     <= hit_pos;
					first_q <= 1'b1;
				end
			end
			S_RUNEND: begin
				if (end_hits != '0) begin
					re_q <= {blk_q, hit_pos};
				end else if (blk_next == nblk) begin
					re_q <= {nblk, 6'd0};
				end else begin
					blk_q   <= blk_next;
					first_q <= 1'b0;
				end
			end
			S_EVAL: begin
				pos_q  <= rs_q;
				last_q <= last_new;
				if (!eval_fail && !restart && last_set) begin
					res_found_q <= 1'b1;
					res_start_q <= rs_q[bris_pkg::START_W-1:0];
					res_len_q   <= len_min[bris_pkg::LEN_W-1:0];
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_found_q <= res_found_q;
					out_start_q <= res_start_q;
					out_len_q   <= res_len_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/bitset_run_intersect_scan_top.sv =====
// channel  | dir | handshake     | word
// ---------+-----+---------------+------------------------------------------------
// in_ch    | in  | valid / ready | kind, bitset_select, word_index, word_value
// out_ch   | out | valid / ready | run_found, run_start, run_length
// apb      | in  | psel/penable  | bitsets_in_use @0x0, element_total @0x4
//
// Write and rewind words are handled in the idle state. A find makes one pass per
// bitset (passes repeat on restart), a start search and then a run-end search over
// the words; the single read port of the word memory sets the pace.
// After reset a clearing pass zeroes all MAX_BITSETS*WORDS_PER_BITSET words (256
// by default) with in_ch.ready low; APB writes are taken throughout. A finished
// result goes to the output register once that is free, and the next word is taken
// meanwhile; until then it waits and in_ch.ready stays low.
module bitset_run_intersect_scan_top #(
	parameter int MAX_BITSETS      = bris_pkg::MAX_BITSETS_DEF,
	parameter int WORDS_PER_BITSET = bris_pkg::WORDS_PER_BITSET_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bris_pkg::APB_AW-1:0] paddr,
	input  logic [bris_pkg::APB_DW-1:0] pwdata,
	output logic [bris_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	bris_in_if.sink                     in_ch,
	bris_out_if.source                  out_ch
);

	localparam int DEPTH  = MAX_BITSETS * WORDS_PER_BITSET;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	bris_pkg::cfg_t                 cfg;
	logic                           mem_we;
	logic [ADDR_W-1:0]              mem_waddr;
	logic [bris_pkg::WORD_BITS-1:0] mem_wdata;
	logic                           mem_re;
	logic [ADDR_W-1:0]              mem_raddr;
	logic [bris_pkg::WORD_BITS-1:0] mem_rdata;

	bris_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bris_ram #(
		.WIDTH (bris_pkg::WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bris_scan #(
		.MAX_BITSETS      (MAX_BITSETS),
		.WORDS_PER_BITSET (WORDS_PER_BITSET)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

// ===== hw/rtl/bris_checker.sv =====
module bris_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         run_found,
	input logic [bris_pkg::START_W-1:0] run_start,
	input logic [bris_pkg::LEN_W-1:0]   run_length
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(run_found)
			&& $stable(run_start) && $stable(run_length))
		else $error("result word changed while stalled");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_found |-> run_start == '0 && run_length == '0)
		else $error("not-found word carries a run");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_found |-> run_length != '0)
		else $error("found run of zero length");

	// memory clearing keeps the input closed from the first reset edge on
	a_reset_closed: assert property (@(posedge clk) !arst_n |=> !in_ready)
		else $error("input open during reset");

endmodule

bind bitset_run_intersect_scan_top bris_checker u_bris_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.run_found  (out_ch.run_found),
	.run_start  (out_ch.run_start),
	.run_length (out_ch.run_length)
);

// ===== test/bitset_run_intersect_scan_top_tb.sv =====
module bitset_run_intersect_scan_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bris_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int BIT_POS_MASK  = 'h3F;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic               found;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
	} run_t;

	// Mirror of the bitset store, the cursor and the two registers; one expected
	// run per accepted find word.
	class run_scoreboard;
		word_t               store [MAX_BITSETS_DEF][WORDS_PER_BITSET_DEF];
		logic [CURSOR_W-1:0] cursor;
		logic [NSET_W-1:0]   nset;
		logic [TOTAL_W-1:0]  total;
		run_t                expected_runs [$];
		int                  errors;
		int                  finds_seen;
		int                  runs_found;
		int                  words_written;

		function new();
			foreach (store[s, w]) store[s][w] = '0;
			cursor = '0;
			nset = NSET_W'(1);
			total = '0;
			errors = 0;
			finds_seen = 0;
			runs_found = 0;
			words_written = 0;
		endfunction

		function void set_reg(logic reg_idx, logic [APB_DW-1:0] value);
			if (reg_idx == REG_BITSETS_IN_USE) begin
				nset = value[NSET_W-1:0];
			end else begin
				total = value[TOTAL_W-1:0];
			end
		endfunction

		// first run of set bits at or after pos within the first nblk words
		function bit run_in_set(int set, int unsigned pos, int unsigned nblk,
				output int unsigned rs, output int unsigned re);
			int unsigned blk, s, eb, e;
			word_t       v, rem;
			blk = pos >> 6;
			s = pos & BIT_POS_MASK;
			if (blk >= nblk) return 1'b0;
			v = store[set][blk];
			rem = ALL_ONES << s;
			while ((v & rem) == '0) begin
				blk++;
				if (blk >= nblk) return 1'b0;
				s = 0;
				rem = ALL_ONES;
				v = store[set][blk];
			end
			while (s < 63 && !v[s]) s++;
			eb = blk;
			e = s;
			rem = ALL_ONES << e;
			// run reaching the last word in use ends there
			while ((v & rem) == rem) begin
				e = 0;
				eb++;
				if (eb == nblk) break;
				v = store[set][eb];
				rem = ALL_ONES;
			end
			if (eb != nblk) begin
				while (e < 63 && v[e]) e++;
			end
			rs = blk * WORD_BITS + s;
			re = eb * WORD_BITS + e;
			return 1'b1;
		endfunction

		function run_t intersect_next();
			int unsigned n, tot, nblk, first, last, len, rs, re, i;
			run_t        r;
			r = '0;
			n = nset;
			if (n < 1) n = 1;
			if (n > MAX_BITSETS_DEF) n = MAX_BITSETS_DEF;
			tot = total;
			if (tot == 0) begin
				cursor = '0;
				return r;
			end
			nblk = ((tot - 1) >> 6) + 1;
			if (nblk > WORDS_PER_BITSET_DEF) nblk = WORDS_PER_BITSET_DEF;
			first = cursor;
			last = 0;
			len = 0;
			i = 0;
			while (i < n) begin
				if (!run_in_set(i, first, nblk, rs, re)) begin
					cursor = '0;
					return r;
				end
				first = rs;
				if (first >= tot || first == re) begin
					cursor = '0;
					return r;
				end
				if (i > 0) begin
					// later run starting at or past the common end: start again from set 0
					if (first >= last) begin
						i = 0;
						continue;
					end
					if (re > last) re = last;
				end
				last = re;
				len = last - first;
				if (len > tot - first) len = tot - first;
				i++;
			end
			r.found = 1'b1;
			r.start = START_W'(first);
			r.length = LEN_W'(len);
			cursor = CURSOR_W'(last);
			runs_found++;
			return r;
		endfunction

		function void note_item(logic [KIND_W-1:0] kind, logic [SEL_W-1:0] sel,
				logic [WIDX_W-1:0] idx, word_t value);
			case (kind)
				KIND_WRITE: begin
					store[sel][idx] = value;
					words_written++;
				end
				KIND_FIND: begin
					expected_runs.push_back(intersect_next());
					finds_seen++;
				end
				KIND_REWIND: begin
					cursor = '0;
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_result(logic found, logic [START_W-1:0] start, logic [LEN_W-1:0] length);
			run_t exp_run;
			if (expected_runs.size() == 0) begin
				report($sformatf("result with none expected (found %0d start %0d length %0d)",
					found, start, length));
				return;
			end
			exp_run = expected_runs.pop_front();
			if (found !== exp_run.found)
				report($sformatf("run_found %0d, expected %0d", found, exp_run.found));
			if (start !== exp_run.start)
				report($sformatf("run_start %0d, expected %0d", start, exp_run.start));
			if (length !== exp_run.length)
				report($sformatf("run_length %0d, expected %0d", length, exp_run.length));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bris_in_if  in_ch ();
	bris_out_if out_ch ();

	run_scoreboard sb = new();

	int send_idle  = 0;
	int recv_stall = 0;
	bit want_hold  = 1'b0;
	int hold_left  = 0;
	int settings_used = 0;

	bitset_run_intersect_scan_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (want_hold) begin
			hold_left = HOLD_CYCLES;
			want_hold = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			sb.check_result(out_ch.run_found, out_ch.run_start, out_ch.run_length);
		end
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("bitset_run_intersect_scan_top test failed");
		$finish;
	end

	task automatic send_item(logic [KIND_W-1:0] kind, logic [SEL_W-1:0] sel,
			logic [WIDX_W-1:0] idx, word_t value);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.kind          <= kind;
		in_ch.bitset_select <= sel;
		in_ch.word_index    <= idx;
		in_ch.word_value    <= value;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_item(kind, sel, idx, value);
	endtask

	task automatic apb_write(logic reg_idx, logic [APB_DW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_reg(reg_idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// block idle: every result in, and a margin for a trailing write word
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.expected_runs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(int nset, int total);
		settle();
		apb_write(REG_BITSETS_IN_USE, APB_DW'(nset));
		apb_write(REG_ELEMENT_TOTAL, APB_DW'(total));
		settings_used++;
	endtask

	function automatic word_t rand_word();
		int    lo, hi;
		word_t w;
		lo = $urandom_range(0, 63);
		hi = $urandom_range(63, lo);
		case ($urandom_range(0, 5))
			0: w = '0;
			1: w = ALL_ONES;
			2: w = {$urandom, $urandom};
			3: w = (ALL_ONES << lo) & (ALL_ONES >> (63 - hi));
			4: w = ~((ALL_ONES << lo) & (ALL_ONES >> (63 - hi)));
			default: w = {$urandom, $urandom} & {$urandom, $urandom};
		endcase
		return w;
	endfunction

	task automatic random_items(int count);
		int                span;
		int                pick;
		logic [KIND_W-1:0] kind;
		logic [WIDX_W-1:0] idx;
		span = (sb.total == 0) ? 1 : ((int'(sb.total) - 1) / WORD_BITS + 1);
		if (span > WORDS_PER_BITSET_DEF) span = WORDS_PER_BITSET_DEF;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) kind = KIND_WRITE;
			else if (pick < 85) kind = KIND_FIND;
			else if (pick < 95) kind = KIND_REWIND;
			else kind = KIND_UNUSED;
			// writes mostly land in the words a scan can reach
			if ($urandom_range(0, 99) < 80) idx = WIDX_W'($urandom_range(0, span - 1));
			else idx = WIDX_W'($urandom_range(0, 63));
			send_item(kind, SEL_W'($urandom_range(0, 3)), idx, rand_word());
		end
	endtask

	task automatic run_phase(int nset, int total, int sidle, int rstall, int count,
			bit pressure);
		configure(nset, total);
		send_idle = sidle;
		recv_stall = rstall;
		if (pressure) begin
			// output held off while finds keep coming, so the input backs up
			send_idle = 0;
			want_hold = 1'b1;
			repeat (30) send_item(KIND_FIND, SEL_W'($urandom_range(0, 3)),
				WIDX_W'($urandom_range(0, 63)), rand_word());
			send_idle = sidle;
		end
		random_items(count);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_WRITE;
		in_ch.bitset_select = '0;
		in_ch.word_index = '0;
		in_ch.word_value = '0;
		out_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: empty table, unused kind, rewind
		send_item(KIND_FIND, '0, '0, '0);
		send_item(KIND_UNUSED, 2'd3, 6'd63, ALL_ONES);
		send_item(KIND_REWIND, '0, '0, '0);

		// zero bitsets acts as one; full table, run across a word edge, run to the end
		configure(0, 4096);
		send_item(KIND_WRITE, 2'd0, 6'd0, ALL_ONES);
		send_item(KIND_WRITE, 2'd0, 6'd1, 64'h0000_0000_0000_000F);
		send_item(KIND_FIND, '0, '0, '0);
		send_item(KIND_FIND, '0, '0, '0);
		send_item(KIND_WRITE, 2'd0, 6'd63, ALL_ONES);
		send_item(KIND_FIND, '0, '0, '0);
		send_item(KIND_FIND, '0, '0, '0);
		send_item(KIND_FIND, '0, '0, '0);

		// count above the maximum acts as four: trimming and a restart
		configure(7, 100);
		send_item(KIND_WRITE, 2'd1, 6'd0, 64'h0000_0000_FFFF_FF00);
		send_item(KIND_WRITE, 2'd2, 6'd0, ALL_ONES);
		send_item(KIND_WRITE, 2'd3, 6'd0, 64'h8000_0000_0000_FFF0);
		send_item(KIND_FIND, '0, '0, '0);
		send_item(KIND_FIND, '0, '0, '0);

		// length clipped to the total, cursor past the table, padding bits
		configure(1, 100);
		send_item(KIND_WRITE, 2'd0, 6'd0, '0);
		send_item(KIND_WRITE, 2'd0, 6'd1, 64'hFFFF_FFFF_FFFF_FFF0);
		send_item(KIND_FIND, '0, '0, '0);
		send_item(KIND_FIND, '0, '0, '0);
		send_item(KIND_WRITE, 2'd0, 6'd1, 64'hF000_0000_0000_0000);
		send_item(KIND_FIND, '0, '0, '0);

		// total beyond the store
		configure(1, 8191);
		send_item(KIND_FIND, '0, '0, '0);

		run_phase(4, 4096, 0, 0, 100, 1'b0);
		run_phase(1, 64, 86, 0, 100, 1'b0);
		run_phase(2, 200, 0, 86, 100, 1'b0);
		run_phase(3, 4095, 38, 38, 100, 1'b0);
		run_phase(0, 1, 0, 0, 100, 1'b0);
		run_phase(7, 8191, 86, 0, 80, 1'b0);
		run_phase($urandom_range(0, 7), $urandom_range(1, 1024), 0, 86, 100, 1'b0);
		run_phase(4, 512, 38, 38, 100, 1'b1);

		recv_stall = 0;
		settle();
		$display("covered %0d word writes and %0d finds (%0d runs, %0d exhausted)",
			sb.words_written, sb.finds_seen, sb.runs_found, sb.finds_seen - sb.runs_found);
		$display("over %0d register settings, idle and stall mixes and one long hold-off",
			settings_used);
		if (sb.errors == 0 && sb.expected_runs.size() == 0) begin
			$display("bitset_run_intersect_scan_top test passed");
		end else begin
			$display("bitset_run_intersect_scan_top test failed");
		end
		$finish;
	end

endmodule
